>>> hw/rtl/qsse_pkg.sv
// ----------------------------------------------------------------------------
// qsse_pkg
// Shared constants of the quicksort stack engine.
// ----------------------------------------------------------------------------
package qsse_pkg;

  localparam int unsigned TALLY_WIDTH = 16;
  localparam logic [TALLY_WIDTH-1:0] TALLY_MAX = '1;

  // Pending ranges the explicit stack can hold; a push onto a full stack is dropped.
  localparam int unsigned STACK_DEPTH = 16;

endpackage

>>> hw/rtl/qsse_ram.sv
// ----------------------------------------------------------------------------
// qsse_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qsse_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/quicksort_stack_engine.sv
// ----------------------------------------------------------------------------
// quicksort_stack_engine
// Loads a set of signed values, sorts them with an iterative quicksort
// (first-element pivot, two scans, explicit range stack) and streams them out.
// ----------------------------------------------------------------------------
//   channel  direction  tdata fields (low bit up)                  tuser/tlast
//   s_axis   in         item_value                                 tlast=is_last
//   m_axis   out        sorted_value, move_count, compare_count    tlast=last_out
//
// Loading takes one cycle per transfer. Each range is popped, its stack entry
// read and its pivot read; each scan step moves the index, then checks the
// value (unless it ran off the range end); each pass ends in a decision state,
// each swap writes both elements in turn, and a closing swap is followed by
// the two pushes. Each sorted value is read from RAM, registered and held until
// transferred before the next is read. Reset is synchronous and clears state,
// load count, stack pointer, tallies and tvalid but not RAM contents. No input
// is taken from the last transfer of a set until its final result is sent.
module quicksort_stack_engine #(
  parameter int MAX_ELEMENTS = 32,
  parameter int VALUE_WIDTH  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,   // item_value
  input  logic                                  s_axis_tlast,   // is_last
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // sorted_value, move_count, compare_count
  output logic [((VALUE_WIDTH + 2 * qsse_pkg::TALLY_WIDTH + 7) / 8) * 8-1:0] m_axis_tdata,
  output logic                                  m_axis_tlast    // last_out
);

  localparam int TW      = qsse_pkg::TALLY_WIDTH;
  localparam int DW_OUT  = ((VALUE_WIDTH + 2 * TW + 7) / 8) * 8;
  localparam int AW      = $clog2(MAX_ELEMENTS);
  localparam int CW      = $clog2(MAX_ELEMENTS + 1);
  localparam int IW      = AW + 2;                // signed index, room for -1 and N
  localparam int SDEPTH  = qsse_pkg::STACK_DEPTH;
  localparam int SAW     = $clog2(SDEPTH);
  localparam int SPW     = $clog2(SDEPTH + 1);

  localparam logic signed [IW-1:0] ONE_I    = IW'(1);
  localparam logic [AW-1:0]        LAST_IDX = AW'(MAX_ELEMENTS - 1);

  localparam logic [3:0] ST_LOAD   = 4'd0;
  localparam logic [3:0] ST_POP    = 4'd1;
  localparam logic [3:0] ST_STKRD  = 4'd2;
  localparam logic [3:0] ST_PIV    = 4'd3;
  localparam logic [3:0] ST_LOSTEP = 4'd4;
  localparam logic [3:0] ST_LOCHK  = 4'd5;
  localparam logic [3:0] ST_HISTEP = 4'd6;
  localparam logic [3:0] ST_HICHK  = 4'd7;
  localparam logic [3:0] ST_DECIDE = 4'd8;
  localparam logic [3:0] ST_SW1    = 4'd9;
  localparam logic [3:0] ST_SW2    = 4'd10;
  localparam logic [3:0] ST_PSH1   = 4'd11;
  localparam logic [3:0] ST_PSH2   = 4'd12;
  localparam logic [3:0] ST_ORD    = 4'd13;
  localparam logic [3:0] ST_OUT    = 4'd14;
  localparam logic [3:0] ST_WAIT   = 4'd15;

  logic [3:0]             state;
  logic [CW-1:0]          load_count;
  logic [SPW-1:0]         sp;
  logic [TW-1:0]          swaps, compares;
  logic signed [IW-1:0]   left, right, lo, hi;
  logic [VALUE_WIDTH-1:0] piv, lo_val, hi_val;
  logic                   close_swap;
  logic [AW-1:0]          out_idx;

  // Element RAM.
  logic                   e_we;
  logic [AW-1:0]          e_waddr, e_raddr;
  logic [VALUE_WIDTH-1:0] e_wdata, e_rdata;

  qsse_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_ELEMENTS)) u_elem (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  // Range stack RAM: {start, end}.
  logic            s_we;
  logic [SAW-1:0]  s_waddr, s_raddr;
  logic [2*AW-1:0] s_wdata, s_rdata;

  qsse_ram #(.WIDTH(2 * AW), .DEPTH(SDEPTH)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  logic signed [IW-1:0] lo_inc, hi_dec, hi_inc;
  logic                 s_fire, m_fire, stack_room;
  logic [TW-1:0]        cmp_inc;

  assign s_fire     = s_axis_tvalid && s_axis_tready;
  assign m_fire     = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state == ST_LOAD);
  assign lo_inc     = lo + ONE_I;
  assign hi_dec     = hi - ONE_I;
  assign hi_inc     = hi + ONE_I;
  assign stack_room = (sp < SPW'(SDEPTH));
  assign cmp_inc    = (compares == qsse_pkg::TALLY_MAX) ? compares : compares + TW'(1);

  always_comb begin
    e_we    = 1'b0;
    e_waddr = lo[AW-1:0];
    e_wdata = hi_val;
    e_raddr = lo_inc[AW-1:0];
    s_we    = 1'b0;
    s_waddr = sp[SAW-1:0];
    s_wdata = {left[AW-1:0], hi_dec[AW-1:0]};
    s_raddr = SAW'(sp - SPW'(1));
    unique case (state)
      ST_LOAD: begin
        e_we    = s_fire && (load_count < CW'(MAX_ELEMENTS));
        e_waddr = load_count[AW-1:0];
        e_wdata = s_axis_tdata[VALUE_WIDTH-1:0];
        s_we    = s_fire && s_axis_tlast && (load_count >= CW'(1));
        s_waddr = '0;
        s_wdata = {{AW{1'b0}}, e_we ? load_count[AW-1:0] : LAST_IDX};
      end
      // The pivot read is addressed straight from the popped stack entry.
      ST_STKRD:  e_raddr = s_rdata[2*AW-1:AW];
      ST_LOSTEP: e_raddr = lo_inc[AW-1:0];
      ST_HISTEP: e_raddr = hi_dec[AW-1:0];
      ST_SW1: begin
        e_we    = 1'b1;
        e_waddr = close_swap ? left[AW-1:0] : lo[AW-1:0];
        e_wdata = hi_val;
      end
      ST_SW2: begin
        e_we    = 1'b1;
        e_waddr = hi[AW-1:0];
        e_wdata = close_swap ? piv : lo_val;
      end
      ST_PSH1: s_we = (hi_dec > left) && stack_room;
      ST_PSH2: begin
        s_we    = (hi_inc < right) && stack_room;
        s_wdata = {hi_inc[AW-1:0], right[AW-1:0]};
      end
      ST_ORD: e_raddr = out_idx;
      default: ;
    endcase
  end

  // Compare values signed.
  logic lo_lt, hi_gt;
  assign lo_lt = $signed(e_rdata) < $signed(piv);
  assign hi_gt = $signed(e_rdata) > $signed(piv);

  logic [TW-1:0] swaps_inc;
  assign swaps_inc = (swaps == qsse_pkg::TALLY_MAX) ? swaps : swaps + TW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      load_count    <= '0;
      sp            <= '0;
      swaps         <= '0;
      compares      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (s_fire) begin
            if (load_count < CW'(MAX_ELEMENTS)) begin
              load_count <= load_count + CW'(1);
            end
            if (s_axis_tlast) begin
              swaps    <= '0;
              compares <= '0;
              out_idx  <= '0;
              // A set of one value skips the sort.
              if (load_count >= CW'(1)) begin
                sp    <= SPW'(1);
                state <= ST_POP;
              end else begin
                sp    <= '0;
                state <= ST_ORD;
              end
            end
          end
        end
        ST_POP: begin
          if (sp == '0) begin
            state <= ST_ORD;
          end else begin
            sp    <= sp - SPW'(1);
            state <= ST_STKRD;
          end
        end
        ST_STKRD: begin
          left  <= $signed({2'b00, s_rdata[2*AW-1:AW]});
          right <= $signed({2'b00, s_rdata[AW-1:0]});
          lo    <= $signed({2'b00, s_rdata[2*AW-1:AW]});
          hi    <= $signed({2'b00, s_rdata[AW-1:0]}) + ONE_I;
          state <= ST_PIV;
        end
        ST_PIV: begin
          piv   <= e_rdata;
          state <= ST_LOSTEP;
        end
        ST_LOSTEP: begin
          lo       <= lo_inc;
          compares <= cmp_inc;
          state    <= (lo_inc <= right) ? ST_LOCHK : ST_HISTEP;
        end
        ST_LOCHK: begin
          if (lo_lt) begin
            state <= ST_LOSTEP;
          end else begin
            lo_val <= e_rdata;
            state  <= ST_HISTEP;
          end
        end
        ST_HISTEP: begin
          hi       <= hi_dec;
          compares <= cmp_inc;
          state    <= (hi_dec >= left) ? ST_HICHK : ST_DECIDE;
        end
        ST_HICHK: begin
          if (hi_gt) begin
            state <= ST_HISTEP;
          end else begin
            hi_val <= e_rdata;
            state  <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          // Crossed scans end the pass with the pivot swap into hi.
          close_swap <= !(lo < hi);
          state      <= ST_SW1;
        end
        ST_SW1: begin
          swaps <= swaps_inc;
          state <= ST_SW2;
        end
        ST_SW2: state <= close_swap ? ST_PSH1 : ST_LOSTEP;
        ST_PSH1: begin
          if (s_we) begin
            sp <= sp + SPW'(1);
          end
          state <= ST_PSH2;
        end
        ST_PSH2: begin
          if (s_we) begin
            sp <= sp + SPW'(1);
          end
          state <= ST_POP;
        end
        ST_ORD: state <= ST_OUT;
        ST_OUT: begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata  <= DW_OUT'({compares, swaps, e_rdata});
          m_axis_tlast  <= (CW'(out_idx) == load_count - CW'(1));
          state         <= ST_WAIT;
        end
        ST_WAIT: begin
          if (m_fire) begin
            m_axis_tvalid <= 1'b0;
            if (m_axis_tlast) begin
              load_count <= '0;
              state      <= ST_LOAD;
            end else begin
              out_idx <= out_idx + AW'(1);
              state   <= ST_ORD;
            end
          end
        end
      endcase
    end
  end

endmodule

>>> tb/quicksort_stack_engine_tb.sv
// ----------------------------------------------------------------------------
// quicksort_stack_engine_tb
// Sends sets of signed values to the quicksort engine and checks every sorted
// result, with its swap and compare counts, against a predictor in this file.
// Both stream sides idle and stall at random in several phases.
// ----------------------------------------------------------------------------
module quicksort_stack_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NMAX   = 32;
  localparam int DW_IN  = 16;
  localparam int DW_OUT = 48;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [15:0] value;
    logic        last;
    logic [15:0] moves;
    logic [15:0] compares;
  } sorted_item_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DW_IN-1:0]  s_axis_tdata = '0;
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DW_OUT-1:0] m_axis_tdata;
  logic              m_axis_tlast;

  quicksort_stack_engine DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_item_t sorted_queue[$];
  int errors = 0;
  int items_sent = 0;
  int sets_sorted = 0;
  int results_seen = 0;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  // Predictor state.
  logic signed [15:0] pred_store[NMAX];
  int pred_count = 0;
  logic signed [15:0] range_lo[16];
  logic signed [15:0] range_hi[16];
  int pred_sp;
  int pred_swaps;
  int pred_compares;

  task automatic tally_compare();
    if (pred_compares < 65535) pred_compares++;
  endtask

  task automatic swap_pair(int a, int b);
    logic signed [15:0] t;
    t = pred_store[a];
    pred_store[a] = pred_store[b];
    pred_store[b] = t;
    if (pred_swaps < 65535) pred_swaps++;
  endtask

  task automatic push_range(int s, int e);
    if (pred_sp < 16) begin
      range_lo[pred_sp] = 16'(s);
      range_hi[pred_sp] = 16'(e);
      pred_sp++;
    end
  endtask

  task automatic sort_and_expect(int n);
    int s, e, lo, hi, k;
    logic signed [15:0] piv;
    sorted_item_t it;
    pred_swaps = 0;
    pred_compares = 0;
    pred_sp = 0;
    if (n >= 2) push_range(0, n - 1);
    while (pred_sp > 0) begin
      pred_sp--;
      s = range_lo[pred_sp];
      e = range_hi[pred_sp];
      piv = pred_store[s];
      lo = s;
      hi = e + 1;
      do begin
        do begin
          lo++;
          tally_compare();
        end while (lo <= e && pred_store[lo < NMAX ? lo : 0] < piv);
        do begin
          hi--;
          tally_compare();
        end while (hi >= s && pred_store[hi] > piv);
        if (lo < hi) swap_pair(lo, hi);
      end while (lo < hi);
      swap_pair(s, hi);
      if (hi - 1 > s) push_range(s, hi - 1);
      if (hi + 1 < e) push_range(hi + 1, e);
    end
    for (k = 0; k < n; k++) begin
      it.value    = pred_store[k];
      it.last     = (k == n - 1);
      it.moves    = pred_swaps[15:0];
      it.compares = pred_compares[15:0];
      sorted_queue.push_back(it);
    end
    sets_sorted++;
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch at result %0d: %s got %0h expected %0h", results_seen, what, got, want);
    errors++;
  endtask

  // Output side: random stalls, long hold-offs and result checking.
  always @(posedge clk) begin
    sorted_item_t want;
    cycles <= cycles + 1;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (sorted_queue.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[15:0], 16'h0000);
      end else begin
        want = sorted_queue.pop_front();
        if (m_axis_tdata[15:0] !== want.value)
          report_mismatch("sorted_value", m_axis_tdata[15:0], want.value);
        if (m_axis_tlast !== want.last)
          report_mismatch("last_out", 16'(m_axis_tlast), 16'(want.last));
        if (m_axis_tdata[31:16] !== want.moves)
          report_mismatch("move_count", m_axis_tdata[31:16], want.moves);
        if (m_axis_tdata[47:32] !== want.compares)
          report_mismatch("compare_count", m_axis_tdata[47:32], want.compares);
      end
      results_seen++;
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Sends one value; the predictor sees it once the transfer is accepted.
  task automatic send_value(logic [15:0] v, logic last);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    if (pred_count < NMAX) begin
      pred_store[pred_count] = v;
      pred_count++;
    end
    if (last) begin
      sort_and_expect(pred_count);
      pred_count = 0;
    end
  endtask

  task automatic send_random_set(int n);
    int k;
    logic [15:0] v;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(3))
        0: v = 16'($urandom_range(3));
        1: v = $urandom_range(1) ? 16'h8000 : 16'h7fff;
        default: v = 16'($urandom);
      endcase
      send_value(v, k == n - 1);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sorted_queue.size() != 0) @(posedge clk);
  endtask

  task automatic test_single_value();
    send_value(16'h1234, 1'b1);
    send_value(16'h8000, 1'b1);
  endtask

  task automatic test_extremes();
    send_value(16'h7fff, 1'b0);
    send_value(16'h8000, 1'b1);
    send_value(16'h0000, 1'b0);
    send_value(16'hffff, 1'b0);
    send_value(16'h7fff, 1'b0);
    send_value(16'h8000, 1'b0);
    send_value(16'h0001, 1'b0);
    send_value(16'h0001, 1'b1);
  endtask

  task automatic test_store_full();
    int k;
    // More than the store holds; the extra values, the last among them, are dropped.
    for (k = 0; k < NMAX + 3; k++) send_value(16'(NMAX - k), k == NMAX + 2);
  endtask

  task automatic test_random_phase(int pct_idle, int pct_stall, int items);
    int sent;
    idle_pct = pct_idle;
    stall_pct = pct_stall;
    sent = 0;
    while (sent < items) begin
      automatic int n = ($urandom_range(9) == 0) ? $urandom_range(20, 36)
                                                  : $urandom_range(1, 10);
      send_random_set(n);
      sent += n;
    end
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 400;
    send_random_set(6);
    send_random_set(5);
    drain();
    // Sender waits here until every result has arrived.
    send_random_set(4);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_value();
    test_extremes();
    test_store_full();
    drain();
    test_random_phase(0, 0, 25);
    test_random_phase(53, 0, 25);
    test_random_phase(0, 53, 25);
    test_random_phase(31, 31, 25);
    test_backpressure();
    drain();
    repeat (200) @(posedge clk);
    $display("%0d values sent in %0d sets, %0d sorted results checked", items_sent,
             sets_sorted, results_seen);
    $display("covered single values, extremes, a full store, stalls and hold-offs");
    if (errors == 0 && sorted_queue.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> quicksort_stack_engine.f
hw/rtl/qsse_pkg.sv
hw/rtl/qsse_ram.sv
hw/rtl/quicksort_stack_engine.sv
tb/quicksort_stack_engine_tb.sv
